// ----- rtl/scl_pkg.sv -----
// Shared types, character constants and the per-byte lexing step for the
// script character lexer. No dependencies; imported by all rtl modules.
package scl_pkg;

  localparam int POS_BITS = 16;      // byte position counter width (8..32)
  localparam int QDEPTH   = 8;       // result queue entries
  localparam int QAW      = $clog2(QDEPTH);
  localparam int MAX_PUSH = 4;       // most results one transaction can cause
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_NUMBER, KIND_WORD, KIND_OP, KIND_EOS
  } token_kind_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_PLUS, OP_MINUS, OP_STAR, OP_SLASH, OP_GT, OP_LT, OP_ASSIGN,
    OP_RBRACK, OP_LBRACK, OP_LPAREN, OP_RPAREN, OP_RBRACE, OP_LBRACE,
    OP_COMMA, OP_BANG, OP_DOT, OP_COLON, OP_SEMI,
    OP_LE, OP_GE, OP_NE, OP_EQ, OP_SCOPE
  } op_code_t;

  typedef struct packed {
    logic        inside_string;
    logic        quote_is_double;
    logic        inside_line_comment;
    logic        inside_block_comment;
    logic [15:0] word_length;
    logic        word_starts_digit;
  } lex_state_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [15:0] start_position;
    logic [15:0] token_length;
    op_code_t    operator_code;
  } tok_t;

  typedef struct packed {
    tok_t tok;
    logic last_of_run;
  } out_tok_t;

  // Results of one accepted transaction, handed from front to queue
  typedef struct packed {
    logic                      valid;
    logic [2:0]                n;
    out_tok_t [MAX_PUSH-1:0]   item;
  } push_t;

  typedef struct packed {
    lex_state_t st;
    logic       skip;
    logic       word_v;
    tok_t       word_tok;
    logic       op_v;
    tok_t       op_tok;
  } step_t;

  function automatic op_code_t op_lookup(logic [7:0] c);
    op_code_t r;
    case (c)
      "+":     r = OP_PLUS;
      "-":     r = OP_MINUS;
      "*":     r = OP_STAR;
      "/":     r = OP_SLASH;
      ">":     r = OP_GT;
      "<":     r = OP_LT;
      "=":     r = OP_ASSIGN;
      "]":     r = OP_RBRACK;
      "[":     r = OP_LBRACK;
      "(":     r = OP_LPAREN;
      ")":     r = OP_RPAREN;
      "}":     r = OP_RBRACE;
      "{":     r = OP_LBRACE;
      ",":     r = OP_COMMA;
      "!":     r = OP_BANG;
      ".":     r = OP_DOT;
      ":":     r = OP_COLON;
      ";":     r = OP_SEMI;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic lex_state_t word_add(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    r = s;
    if (s.word_length == 16'd0) r.word_starts_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (s.word_length != LEN_MAX) r.word_length = s.word_length + 16'd1;
    return r;
  endfunction

  // One byte of lexing with optional one-byte lookahead
  function automatic step_t lex_step(lex_state_t s, logic [7:0] c, logic la_ok,
                                     logic [7:0] la, pos_t pos);
    step_t    r;
    logic     is_quote;
    logic     dq;
    op_code_t code;
    op_code_t tc;
    logic [15:0] tl;
    logic [32:0] p_ext;
    logic [32:0] w_ext;
    logic [32:0] st;
    r = '0;
    r.st = s;
    is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    code  = op_lookup(c);
    p_ext = 33'(pos);
    w_ext = 33'(s.word_length);
    st    = (p_ext > w_ext) ? (p_ext - w_ext) : 33'd0;
    tc    = code;
    tl    = 16'd1;
    if (!s.inside_string) begin
      if (code != OP_NONE || is_quote || c == CH_SPACE || c == CH_TAB) begin
        if (s.word_length != 16'd0 && !(s.inside_line_comment || s.inside_block_comment)) begin
          r.word_v = 1'b1;
          r.word_tok.token_kind     = s.word_starts_digit ? KIND_NUMBER : KIND_WORD;
          r.word_tok.start_position = st[15:0];
          r.word_tok.token_length   = s.word_length;
          r.word_tok.operator_code  = OP_NONE;
        end
        if (code != OP_NONE) begin
          if (la_ok && la == CH_EQUAL &&
              (c == CH_LT || c == CH_GT || c == CH_BANG || c == CH_EQUAL)) begin
            r.skip = 1'b1;
            tl = 16'd2;
            tc = (c == CH_LT) ? OP_LE : (c == CH_GT) ? OP_GE : (c == CH_BANG) ? OP_NE : OP_EQ;
          end
          if (la_ok && c == CH_COLON && la == CH_COLON) begin
            r.skip = 1'b1;
            tl = 16'd2;
            tc = OP_SCOPE;
          end
          if (la_ok && c == CH_SLASH && la == CH_STAR) begin
            r.skip = 1'b1;
            r.st.inside_block_comment = 1'b1;
          end else if (la_ok && c == CH_SLASH && la == CH_SLASH) begin
            r.skip = 1'b1;
            r.st.inside_line_comment = 1'b1;
          end
          if (!(r.st.inside_line_comment || r.st.inside_block_comment)) begin
            r.op_v = 1'b1;
            r.op_tok.token_kind     = (c == CH_SEMI) ? KIND_EOS : KIND_OP;
            r.op_tok.start_position = p_ext[15:0];
            r.op_tok.token_length   = tl;
            r.op_tok.operator_code  = tc;
          end
          // "*/" closes only after the star was kept out of the output
          if (la_ok && c == CH_STAR && la == CH_SLASH) begin
            r.skip = 1'b1;
            r.st.inside_block_comment = 1'b0;
          end
        end
        r.st.word_length       = is_quote ? 16'd1 : 16'd0;
        r.st.word_starts_digit = 1'b0;
      end else if (c != CH_NL) begin
        r.st = word_add(r.st, c);
      end else if (s.inside_line_comment) begin
        r.st.inside_line_comment = 1'b0;
        r.st.word_length         = 16'd0;
        r.st.word_starts_digit   = 1'b0;
      end
    end else begin
      r.st = word_add(r.st, c);
    end
    if (!(r.st.inside_line_comment || r.st.inside_block_comment) && is_quote) begin
      dq = (c == CH_DQUOTE);
      if (!r.st.inside_string) begin
        r.st.quote_is_double = dq;
        r.st.inside_string   = 1'b1;
      end else if (dq == r.st.quote_is_double) begin
        if (la_ok && la == c) begin
          // doubled quote: escape, keep both bytes in the string
          r.st   = word_add(r.st, c);
          r.skip = 1'b1;
        end else begin
          r.st.inside_string = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/scl_in_if.sv -----
// Source byte channel: valid/ready handshake with one byte and end marker.
// No dependencies.
interface scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_char;
  logic       end_of_source;

  modport source (output valid, output source_char, output end_of_source, input ready);
  modport sink   (input valid, input source_char, input end_of_source, output ready);
endinterface

// ----- rtl/scl_out_if.sv -----
// Token descriptor channel: valid/ready handshake with one descriptor.
// No dependencies.
interface scl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [15:0] start_position;
  logic [15:0] token_length;
  logic [4:0]  operator_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_position,
                  output token_length, output operator_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input start_position,
                  input token_length, input operator_code, input last_of_run,
                  output ready);
endinterface

// ----- rtl/scl_front.sv -----
// Front end: accepts source bytes, holds one byte of lookahead and lexer state,
// and pushes up to four descriptors per transaction. Uses scl_pkg, scl_in_if.
module scl_front (
  input  logic           clk,
  input  logic           rst_n,
  scl_in_if.sink         in_ch,
  input  logic           push_ready,
  output scl_pkg::push_t push
);
  import scl_pkg::*;

  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       consume_next_r, consume_next_nxt;
  lex_state_t st_r, st_nxt;
  pos_t       pos_r, pos_nxt;

  logic       accept;
  step_t      p1, p2;
  lex_state_t st_a;
  logic       cn_a;
  pos_t       pos_a;
  logic       use_p1, use_p2;
  tok_t       cand [MAX_PUSH];
  logic [MAX_PUSH-1:0] cand_v;
  logic [2:0] cnt;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // held byte first, with the incoming byte as lookahead
  assign p1 = lex_step(st_r, held_char_r, 1'b1, in_ch.source_char, pos_r);

  always_comb begin
    st_a   = st_r;
    cn_a   = consume_next_r;
    pos_a  = pos_r;
    use_p1 = 1'b0;
    if (held_valid_r) begin
      if (consume_next_r) begin
        cn_a = 1'b0;
      end else begin
        st_a   = p1.st;
        cn_a   = p1.skip;
        use_p1 = 1'b1;
      end
      if (pos_r != POS_MAX) pos_a = pos_r + pos_t'(1);
    end
  end

  // final byte on end of source, no lookahead
  assign p2     = lex_step(st_a, in_ch.source_char, 1'b0, 8'h00, pos_a);
  assign use_p2 = in_ch.end_of_source && !cn_a;

  always_comb begin
    cand[0] = p1.word_tok;
    cand[1] = p1.op_tok;
    cand[2] = p2.word_tok;
    cand[3] = p2.op_tok;
    cand_v  = {use_p2 && p2.op_v, use_p2 && p2.word_v, use_p1 && p1.op_v, use_p1 && p1.word_v};
    push    = '0;
    cnt     = 3'd0;
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (cand_v[k]) begin
        push.item[cnt[1:0]].tok = cand[k];
        cnt = cnt + 3'd1;
      end
    end
    if (cnt != 3'd0) push.item[2'(cnt - 3'd1)].last_of_run = 1'b1;
    push.n     = cnt;
    push.valid = accept;
  end

  always_comb begin
    held_valid_nxt   = held_valid_r;
    held_char_nxt    = held_char_r;
    consume_next_nxt = consume_next_r;
    st_nxt           = st_r;
    pos_nxt          = pos_r;
    if (accept) begin
      if (in_ch.end_of_source) begin
        held_valid_nxt   = 1'b0;
        held_char_nxt    = 8'h00;
        consume_next_nxt = 1'b0;
        st_nxt           = '0;
        pos_nxt          = '0;
      end else begin
        held_valid_nxt   = 1'b1;
        held_char_nxt    = in_ch.source_char;
        consume_next_nxt = cn_a;
        st_nxt           = st_a;
        pos_nxt          = pos_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r   <= 1'b0;
      held_char_r    <= 8'h00;
      consume_next_r <= 1'b0;
      st_r           <= '0;
      pos_r          <= '0;
    end else begin
      held_valid_r   <= held_valid_nxt;
      held_char_r    <= held_char_nxt;
      consume_next_r <= consume_next_nxt;
      st_r           <= st_nxt;
      pos_r          <= pos_nxt;
    end
  end

  a_skip_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    consume_next_r |-> held_valid_r)
    else $error("lookahead skip pending without a held byte");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.end_of_source |=> !held_valid_r && !consume_next_r && pos_r == '0)
    else $error("end of source did not return front to reset state");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && push.n != 3'd0 |-> push.item[2'(push.n - 3'd1)].last_of_run)
    else $error("final descriptor of a transaction lacks last_of_run");

endmodule

// ----- rtl/scl_queue.sv -----
// Back end: result queue taking up to four descriptors per cycle while room
// lasts, one per cycle out while ready is high. Uses scl_pkg, scl_out_if.
module scl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  scl_pkg::push_t push,
  output logic           push_ready,
  scl_out_if.source      out_ch
);
  import scl_pkg::*;

  out_tok_t           mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]       count_r, count_nxt;
  logic               pop;
  logic [QAW:0]       push_n;
  out_tok_t           head;

  // room for a full burst must be there before a byte is taken
  assign push_ready = count_r <= (QAW+1)'(QDEPTH - MAX_PUSH);
  assign push_n     = push.valid ? (QAW+1)'(push.n) : '0;
  assign pop        = out_ch.valid && out_ch.ready;
  assign head       = mem_r[rd_ptr_r];

  assign out_ch.valid          = count_r != '0;
  assign out_ch.token_kind     = head.tok.token_kind;
  assign out_ch.start_position = head.tok.start_position;
  assign out_ch.token_length   = head.tok.token_length;
  assign out_ch.operator_code  = head.tok.operator_code;
  assign out_ch.last_of_run    = head.last_of_run;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n[QAW-1:0];
    rd_ptr_nxt = rd_ptr_r + (pop ? QAW'(1) : QAW'(0));
    count_nxt  = count_r + push_n - (pop ? (QAW+1)'(1) : (QAW+1)'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PUSH; k++) begin
      if (push.valid && 3'(k) < push.n) mem_r[wr_ptr_r + QAW'(k)] <= push.item[k];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("result queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[QAW-1:0] == QAW'(wr_ptr_r - rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> count_r <= (QAW+1)'(QDEPTH - MAX_PUSH))
    else $error("burst pushed without room for it");

endmodule

// ----- rtl/script_char_lexer_core.sv -----
// Script character lexer, top level. Uses scl_pkg, scl_in_if, scl_out_if,
// scl_front and scl_queue.
//
// Usage: source text enters on in_ch, one byte per transaction, with
// end_of_source set on the final byte. Token descriptors leave on out_ch
// (kind, start position, length, operator code); last_of_run marks the final
// descriptor caused by one transaction, and a transaction may cause none.
// Each byte is lexed one transaction late, since it needs the next byte as
// lookahead; the end-of-source byte flushes the held byte and itself, then
// the lexer returns to its reset state for the next text.
// Throughput: one byte per cycle while the 8-entry result queue has room for
// four more descriptors; descriptors leave at one per cycle while out_ch is
// ready, so the queue drain rate sets the sustained rate on token-dense text.
// A descriptor is written into the result queue by the transaction that
// caused it, and is shown on out_ch once it reaches the queue head.
// Reset (rst_n low, synchronous) empties the queue and clears lexer state.
// When the receiver stalls, the queue fills and in_ch.ready drops once fewer
// than four entries are free; no descriptor is lost.
module script_char_lexer_core (
  input  logic      clk,
  input  logic      rst_n,
  scl_in_if.sink    in_ch,
  scl_out_if.source out_ch
);
  import scl_pkg::*;

  push_t push;
  logic  push_ready;

  scl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push       (push)
  );

  scl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule
